// ===== src/u2da_pkg.sv =====
// Package for the unsigned to decimal ASCII converter.
// Holds field widths, the ASCII offset and the control struct shared by the
// top level and the double-dabble core. Depends on nothing.
package u2da_pkg;

  localparam int BIN_WIDTH          = 32;
  localparam int DEC_DIGITS         = 10;
  localparam int DIGIT_W            = 4;
  localparam int BCD_WIDTH          = DEC_DIGITS * DIGIT_W;
  localparam int CHAR_W             = 6;
  localparam int MAX_DIGITS_DEFAULT = 10;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef struct packed {
    logic load;
    logic dabble;
    logic digit_shift;
  } ctrl_t;

endpackage

// ===== src/u2da_dabble.sv =====
// Bit-serial double-dabble core: a binary shift register feeding a BCD shift
// register, plus a digit-wide shift for emission. Depends on u2da_pkg.
module u2da_dabble (
  input  logic                                   clk,
  input  u2da_pkg::ctrl_t                        ctrl,
  input  logic [u2da_pkg::BIN_WIDTH-1:0]         value,
  output logic [u2da_pkg::DIGIT_W-1:0]           top_digit
);

  localparam int DW = u2da_pkg::DIGIT_W;
  localparam int BW = u2da_pkg::BCD_WIDTH;

  logic [u2da_pkg::BIN_WIDTH-1:0] bin_sr;
  logic [BW-1:0]                  bcd;
  logic [BW-1:0]                  bcd_adj;

  always_comb begin
    for (int i = 0; i < u2da_pkg::DEC_DIGITS; i++) begin
      if (bcd[i*DW +: DW] >= 4'd5) begin
        bcd_adj[i*DW +: DW] = bcd[i*DW +: DW] + 4'd3;
      end else begin
        bcd_adj[i*DW +: DW] = bcd[i*DW +: DW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin_sr <= value;
      bcd    <= '0;
    end else if (ctrl.dabble) begin
      bin_sr <= {bin_sr[u2da_pkg::BIN_WIDTH-2:0], 1'b0};
      bcd    <= {bcd_adj[BW-2:0], bin_sr[u2da_pkg::BIN_WIDTH-1]};
    end else if (ctrl.digit_shift) begin
      bcd    <= {bcd[BW-DW-1:0], {DW{1'b0}}};
    end
  end

  assign top_digit = bcd[BW-1 -: DW];

endmodule

// ===== src/unsigned_to_decimal_ascii.sv =====
// Top level of the unsigned to decimal ASCII converter: handshakes, the
// configuration register and the sequencer. Depends on u2da_pkg, u2da_dabble.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         in_valid / in_ready       value
//   output   out        out_valid / out_ready     digit_char, last
//   config   in         cfg_we (no wait)          cfg_wdata
//
// A nonzero value is loaded, dabbled through all 32 binary bits, shifted
// past each suppressed or dropped leading digit until the first kept digit
// is found, and then sent as one beat for each kept digit. A zero value is
// loaded and sent as its single beat, or leaves the block idle when it
// prints nothing. One value is worked on at a time; in_ready is high only
// while idle. A stalled output beat holds until out_ready. Reset is
// synchronous and returns the sequencer to idle with zero_prints_digit set.
module unsigned_to_decimal_ascii #(
  parameter int MAX_DIGITS = u2da_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [u2da_pkg::BIN_WIDTH-1:0]    value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [u2da_pkg::CHAR_W-1:0]       digit_char,
  output logic                              last,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata
);

  localparam int POS_W  = $clog2(u2da_pkg::DEC_DIGITS + 1);
  localparam int KEEP   = (MAX_DIGITS < u2da_pkg::DEC_DIGITS) ? MAX_DIGITS
                                                              : u2da_pkg::DEC_DIGITS;
  localparam int CNT_W  = $clog2(u2da_pkg::BIN_WIDTH);
  localparam logic [POS_W-1:0] KEEP_POS = POS_W'(KEEP);
  localparam logic [POS_W-1:0] TOP_POS  = POS_W'(u2da_pkg::DEC_DIGITS);
  localparam logic [CNT_W-1:0] CNT_TOP  = CNT_W'(u2da_pkg::BIN_WIDTH - 1);

  typedef enum logic [3:0] {
    IDLE = 4'b0001,
    CONV = 4'b0010,
    SKIP = 4'b0100,
    EMIT = 4'b1000
  } state_t;

  state_t                        state, state_next;
  logic [CNT_W-1:0]              bit_cnt, bit_cnt_next;
  logic [POS_W-1:0]              pos, pos_next;
  logic                          seen, seen_next;
  logic                          zero_prints_digit;
  logic [u2da_pkg::DIGIT_W-1:0]  top_digit;
  logic                          skip_digit;
  u2da_pkg::ctrl_t               ctrl;

  u2da_dabble u_dabble (
    .clk       (clk),
    .ctrl      (ctrl),
    .value     (value),
    .top_digit (top_digit)
  );

  assign skip_digit = (pos > KEEP_POS) || (!seen && top_digit == '0);

  always_comb begin
    state_next       = state;
    bit_cnt_next     = bit_cnt;
    pos_next         = pos;
    seen_next        = seen;
    ctrl.load        = 1'b0;
    ctrl.dabble      = 1'b0;
    ctrl.digit_shift = 1'b0;
    case (state)
      IDLE: begin
        if (in_valid) begin
          ctrl.load    = 1'b1;
          bit_cnt_next = CNT_TOP;
          seen_next    = 1'b0;
          if (value != '0) begin
            pos_next   = TOP_POS;
            state_next = CONV;
          end else if (zero_prints_digit) begin
            pos_next   = POS_W'(1);
            state_next = EMIT;
          end
        end
      end
      CONV: begin
        ctrl.dabble  = 1'b1;
        bit_cnt_next = bit_cnt - CNT_W'(1);
        if (bit_cnt == '0) begin
          state_next = SKIP;
        end
      end
      SKIP: begin
        if (skip_digit) begin
          ctrl.digit_shift = 1'b1;
          pos_next         = pos - POS_W'(1);
          seen_next        = seen || (top_digit != '0);
        end else begin
          state_next = EMIT;
        end
      end
      EMIT: begin
        if (out_ready) begin
          if (pos == POS_W'(1)) begin
            state_next = IDLE;
          end else begin
            ctrl.digit_shift = 1'b1;
            pos_next         = pos - POS_W'(1);
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= IDLE;
      zero_prints_digit <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        zero_prints_digit <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    bit_cnt <= bit_cnt_next;
    pos     <= pos_next;
    seen    <= seen_next;
  end

  assign in_ready   = (state == IDLE);
  assign out_valid  = (state == EMIT);
  assign digit_char = u2da_pkg::ASCII_ZERO + u2da_pkg::CHAR_W'(top_digit);
  assign last       = (pos == POS_W'(1));

  a_emit_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pos != '0) && (pos <= KEEP_POS))
    else $error("Beat emitted at a digit position outside the kept range.");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (top_digit <= 4'd9))
    else $error("BCD digit above nine reached the output.");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("Input and output sides active at once.");

  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && value == '0 && !zero_prints_digit) |=> in_ready)
    else $error("Zero value with printing disabled did not return to idle.");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> in_ready)
    else $error("Final beat did not return the block to idle.");

endmodule
